[rtl/cec_pkg.sv]
`default_nettype none
package cec_pkg;

  // Parameter defaults
  localparam int DEFAULT_TABLE_DEPTH = 16;
  localparam int DEFAULT_KEY_WIDTH   = 32;
  localparam logic [15:0] DEFAULT_FLUSH_DELAY = 16'd500;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Command codes
  localparam logic CMD_EVENT = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Raw and merged event kinds
  typedef enum logic [1:0] {
    KIND_CREATED = 2'd0,
    KIND_DELETED = 2'd1,
    KIND_CHANGED = 2'd2,
    KIND_ATTRIB  = 2'd3
  } kind_t;

  // Classified item control passed from front to back
  typedef struct packed {
    logic  tick;
    kind_t kind;
  } qctl_t;

  // Back end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_RM1,
    ST_RM2,
    ST_INSERT,
    ST_SCAN,
    ST_LAST
  } state_t;

endpackage
`default_nettype wire

[rtl/cec_front.sv]
`default_nettype none
module cec_front #(
  parameter int KEY_WIDTH = cec_pkg::DEFAULT_KEY_WIDTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 command,
  input  wire logic [1:0]           event_kind,
  input  wire logic [KEY_WIDTH-1:0] file_key,
  output logic                      q_valid,
  output cec_pkg::qctl_t            q_ctl,
  output logic [KEY_WIDTH-1:0]      q_key,
  input  wire logic                 q_pop
);
  import cec_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  qctl_t                ctl_q [QUEUE_DEPTH];
  logic [KEY_WIDTH-1:0] key_q [QUEUE_DEPTH];
  logic [PW-1:0]        wr_ptr;
  logic [PW-1:0]        rd_ptr;
  logic [NW-1:0]        count;
  qctl_t                cls;
  logic                 push;
  logic                 pop;

  // Classify: attribute change is a plain change
  always_comb begin
    cls.tick = (command == CMD_TICK);
    case (kind_t'(event_kind))
      KIND_CREATED: cls.kind = KIND_CREATED;
      KIND_DELETED: cls.kind = KIND_DELETED;
      default:      cls.kind = KIND_CHANGED;
    endcase
  end

  assign in_stall = (count == NW'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;
  assign q_valid  = (count != '0);
  assign q_ctl    = ctl_q[rd_ptr];
  assign q_key    = key_q[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      ctl_q[wr_ptr] <= cls;
      key_q[wr_ptr] <= file_key;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/cec_back.sv]
`default_nettype none
module cec_back #(
  parameter int TABLE_DEPTH = cec_pkg::DEFAULT_TABLE_DEPTH,
  parameter int KEY_WIDTH   = cec_pkg::DEFAULT_KEY_WIDTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [15:0]          flush_delay,
  input  wire logic                 q_valid,
  input  wire cec_pkg::qctl_t       q_ctl,
  input  wire logic [KEY_WIDTH-1:0] q_key,
  output logic                      q_pop,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                event_kind_res,
  output logic [KEY_WIDTH-1:0]      file_key_res,
  output logic                      last,
  output logic                      overflow
);
  import cec_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  state_t               state;
  state_t               state_next;
  kind_t                ent_kind [TABLE_DEPTH];
  logic [KEY_WIDTH-1:0] ent_key  [TABLE_DEPTH];
  logic [CW-1:0]        used;
  logic [15:0]          countdown;
  logic                 armed;
  logic                 dropped;
  kind_t                cur_kind;
  logic [KEY_WIDTH-1:0] cur_key;
  logic [TABLE_DEPTH-1:0] vec1;
  logic [TABLE_DEPTH-1:0] vec2;
  kind_t                scan_kind;
  logic [IW-1:0]        scan_idx;
  logic                 held_v;
  kind_t                held_kind;
  logic [KEY_WIDTH-1:0] held_key;

  logic [TABLE_DEPTH-1:0] m_cre;
  logic [TABLE_DEPTH-1:0] m_del;
  logic [TABLE_DEPTH-1:0] m_chg;
  logic [TABLE_DEPTH-1:0] rm_vec;
  logic [IW-1:0]        rm_pos;
  logic                 rm_hit;
  logic                 out_free;
  logic                 out_load;
  logic                 scan_hit;
  logic [IW-1:0]        top_idx;

  assign out_free = !out_valid || !out_stall;
  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign top_idx  = IW'(used - 1'b1);
  assign scan_hit = (ent_kind[scan_idx] == scan_kind);
  // Held result moves to the output register
  assign out_load = held_v && out_free &&
                    ((state == ST_SCAN && scan_hit) || state == ST_LAST);

  // Parallel key compare against the valid prefix
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      logic hit;
      hit = (CW'(i) < used) && (ent_key[i] == cur_key);
      m_cre[i] = hit && (ent_kind[i] == KIND_CREATED);
      m_del[i] = hit && (ent_kind[i] == KIND_DELETED);
      m_chg[i] = hit && (ent_kind[i] == KIND_CHANGED);
    end
  end

  // Newest match to remove
  always_comb begin
    rm_vec = (state == ST_RM1) ? vec1 : vec2;
    rm_hit = |rm_vec;
    rm_pos = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (rm_vec[i]) begin
        rm_pos = IW'(i);
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          if (!q_ctl.tick) begin
            state_next = ST_MATCH;
          end else if (armed && countdown <= 16'd1) begin
            state_next = (used == '0) ? ST_LAST : ST_SCAN;
          end
        end
      end
      ST_MATCH: begin
        if (cur_kind == KIND_CHANGED && |m_cre) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_RM1;
        end
      end
      ST_RM1:    state_next = ST_RM2;
      ST_RM2:    state_next = ST_INSERT;
      ST_INSERT: state_next = ST_IDLE;
      ST_SCAN: begin
        if (out_free && scan_idx == '0 && scan_kind == KIND_CHANGED) begin
          state_next = ST_LAST;
        end
      end
      ST_LAST: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Table payload: shift-down removal and append
  always_ff @(posedge clk) begin
    if ((state == ST_RM1 || state == ST_RM2) && rm_hit) begin
      for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
        if (IW'(i) >= rm_pos) begin
          ent_kind[i] <= ent_kind[i + 1];
          ent_key[i]  <= ent_key[i + 1];
        end
      end
    end
    if (state == ST_INSERT && used != CW'(TABLE_DEPTH)) begin
      ent_kind[used[IW-1:0]] <= cur_kind;
      ent_key[used[IW-1:0]]  <= cur_key;
    end
  end

  // Working registers for the current item and the flush scan
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cur_kind  <= q_ctl.kind;
        cur_key   <= q_key;
        scan_kind <= KIND_CREATED;
        scan_idx  <= top_idx;
      end
      ST_MATCH: begin
        case (cur_kind)
          KIND_CREATED: begin
            vec1 <= m_del;
            vec2 <= '0;
          end
          KIND_DELETED: begin
            vec1 <= m_cre;
            vec2 <= m_chg;
          end
          default: begin
            vec1 <= m_chg;
            vec2 <= '0;
          end
        endcase
      end
      ST_RM1: begin
        if (rm_hit) begin
          // keep the second vector aligned with the shifted table
          for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (IW'(i) >= rm_pos) begin
              vec2[i] <= (i + 1 < TABLE_DEPTH) ? vec2[(i + 1) % TABLE_DEPTH] : 1'b0;
            end
          end
          if (cur_kind == KIND_CREATED) begin
            cur_kind <= KIND_CHANGED;
          end
        end
      end
      ST_SCAN: begin
        if (out_free) begin
          if (scan_hit) begin
            held_kind <= scan_kind;
            held_key  <= ent_key[scan_idx];
          end
          if (scan_idx == '0) begin
            scan_idx <= top_idx;
            case (scan_kind)
              KIND_CREATED: scan_kind <= KIND_DELETED;
              default:      scan_kind <= KIND_CHANGED;
            endcase
          end else begin
            scan_idx <= scan_idx - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control state: fill count, timer, overflow, held result, output register
  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      countdown <= '0;
      armed     <= 1'b0;
      dropped   <= 1'b0;
      held_v    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          held_v <= 1'b0;
          if (q_valid && q_ctl.tick && armed && countdown > 16'd1) begin
            countdown <= countdown - 16'd1;
          end
        end
        ST_RM1, ST_RM2: begin
          if (rm_hit) begin
            used <= used - 1'b1;
          end
        end
        ST_INSERT: begin
          if (used == CW'(TABLE_DEPTH)) begin
            dropped <= 1'b1;
          end else begin
            used      <= used + 1'b1;
            countdown <= flush_delay;
            armed     <= 1'b1;
          end
        end
        ST_SCAN: begin
          if (out_free && scan_hit) begin
            held_v <= 1'b1;
            if (held_v) begin
              event_kind_res <= held_kind;
              file_key_res   <= held_key;
              last           <= 1'b0;
              overflow       <= dropped;
            end
          end
        end
        ST_LAST: begin
          if (out_free) begin
            if (held_v) begin
              event_kind_res <= held_kind;
              file_key_res   <= held_key;
              last           <= 1'b1;
              overflow       <= dropped;
            end
            held_v    <= 1'b0;
            used      <= '0;
            countdown <= '0;
            armed     <= 1'b0;
            dropped   <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/change_event_coalescer_top.sv]
`default_nettype none
// Channel   Handshake              Payload
// cfg       cfg_we                 cfg_wdata (flush_delay)
// in        in_valid / in_stall    command, event_kind, file_key
// out       out_valid / out_stall  event_kind_res, file_key_res, last, overflow
//
// In the back end a file event passes dequeue, key compare, two removal
// steps and append; a change meeting a created entry ends at the compare.
// A flush scans all three kinds, one entry per cycle unless output stalls.
// A two-item queue in front lets input be taken while the back end works.
// Synchronous reset empties the table, disarms the timer, sets delay to 500.
// Output stall holds the flush scan; input stall rises when the queue is full.
module change_event_coalescer_top #(
  parameter int TABLE_DEPTH = cec_pkg::DEFAULT_TABLE_DEPTH,
  parameter int KEY_WIDTH   = cec_pkg::DEFAULT_KEY_WIDTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [15:0]          cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 command,
  input  wire logic [1:0]           event_kind,
  input  wire logic [KEY_WIDTH-1:0] file_key,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                event_kind_res,
  output logic [KEY_WIDTH-1:0]      file_key_res,
  output logic                      last,
  output logic                      overflow
);
  import cec_pkg::*;

  logic [15:0]          flush_delay;
  logic                 q_valid;
  qctl_t                q_ctl;
  logic [KEY_WIDTH-1:0] q_key;
  logic                 q_pop;

  // Delay register
  always_ff @(posedge clk) begin
    if (rst) begin
      flush_delay <= DEFAULT_FLUSH_DELAY;
    end else if (cfg_we) begin
      flush_delay <= cfg_wdata;
    end
  end

  cec_front #(
    .KEY_WIDTH(KEY_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .event_kind(event_kind),
    .file_key  (file_key),
    .q_valid   (q_valid),
    .q_ctl     (q_ctl),
    .q_key     (q_key),
    .q_pop     (q_pop)
  );

  cec_back #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_WIDTH  (KEY_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .flush_delay   (flush_delay),
    .q_valid       (q_valid),
    .q_ctl         (q_ctl),
    .q_key         (q_key),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .event_kind_res(event_kind_res),
    .file_key_res  (file_key_res),
    .last          (last),
    .overflow      (overflow)
  );

endmodule
`default_nettype wire
